// File: rtl/kst_pkg.sv
`timescale 1ns / 1ps

package kst_pkg;

  localparam int unsigned ROW_COUNT     = 64;
  localparam int unsigned ITEMS_PER_ROW = 16;

  localparam int unsigned ROW_IDX_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned ROW_CNT_W  = $clog2(ROW_COUNT + 1);
  localparam int unsigned SLOT_CNT_W = $clog2(ITEMS_PER_ROW + 1);
  localparam int unsigned ITEM_DEPTH = ROW_COUNT * ITEMS_PER_ROW;
  localparam int unsigned ITEM_AW    = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;

  typedef enum logic [2:0] {
    CMD_ADD_ROW     = 3'd0,
    CMD_REMOVE_ROW  = 3'd1,
    CMD_FIND_OWNER  = 3'd2,
    CMD_ADD_ITEM    = 3'd3,
    CMD_REMOVE_ITEM = 3'd4,
    CMD_COUNT       = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_INVALID    = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_NOT_FOUND  = 3'd3,
    STAT_ITEMS_FULL = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] row_key;
    logic [15:0] owner;
    logic [15:0] item;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_key;
    logic [4:0]  item_total;
  } out_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] owner;
  } row_t;

endpackage

// File: rtl/kst_ram.sv
`timescale 1ns / 1ps

module kst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/keyed_slot_table_with_item_lists.sv
`timescale 1ns / 1ps

// Keyed slot table: ROW_COUNT rows of key, owner and ITEMS_PER_ROW item slots.
// One command is worked at a time. Keys and owners sit in a row RAM that is
// scanned one row per cycle (registered read, pipelined); row valid bits
// are flip-flops cleared by reset. Item slots sit in an item RAM scanned one
// slot per cycle. A rejected command goes straight to its result; add row
// searches for a free row, then clears its slots; item and count commands
// search for the key, then scan the slots of that row. A result waits in
// an output register until taken; the next command is accepted once it is loaded.

module keyed_slot_table_with_item_lists (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kst_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kst_pkg::out_t out_o
);

  import kst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_CLEAR,
    S_ROW,
    S_SLOT,
    S_DONE
  } state_e;

  state_e                state_q;
  in_t                   req_q;
  out_t                  res_q;
  out_t                  out_q;
  logic                  out_valid_q;
  logic [ROW_COUNT-1:0]  valid_q;
  logic [ROW_CNT_W-1:0]  r_q;
  logic [ROW_IDX_W-1:0]  cmp_row_q;
  logic                  cmp_q;
  logic [ITEM_AW-1:0]    base_q;
  logic [SLOT_CNT_W-1:0] s_q;
  logic [SLOT_CNT_W-1:0] cnt_q;
  logic [ITEM_AW-1:0]    cmp_addr_q;

  logic [ROW_IDX_W-1:0]  ridx;
  logic                  r_live;
  logic                  s_live;
  logic                  row_we;
  logic                  row_re;
  row_t                  row_wdata;
  row_t                  row_rdata;
  logic                  row_hit;
  logic                  item_we;
  logic                  item_re;
  logic [ITEM_AW-1:0]    item_raddr;
  logic [ITEM_AW-1:0]    item_waddr;
  logic [15:0]           item_wdata;
  logic [15:0]           item_rdata;
  logic                  slot_hit;
  logic                  bad_req;
  logic                  out_load;

  assign ridx   = r_q[ROW_IDX_W-1:0];
  assign r_live = (r_q < ROW_CNT_W'(ROW_COUNT));
  assign s_live = (s_q < SLOT_CNT_W'(ITEMS_PER_ROW));

  assign row_we    = (state_q == S_FREE) && r_live && !valid_q[ridx];
  assign row_wdata = '{key: req_q.row_key, owner: req_q.owner};
  assign row_re    = (state_q == S_ROW) && r_live;

  assign row_hit = cmp_q && valid_q[cmp_row_q] &&
                   ((req_q.cmd == CMD_FIND_OWNER) ? (row_rdata.owner == req_q.owner)
                                                  : (row_rdata.key == req_q.row_key));

  assign item_raddr = base_q + ITEM_AW'(s_q);
  assign item_re    = (state_q == S_SLOT) && s_live;
  assign slot_hit   = (req_q.cmd == CMD_ADD_ITEM) ? (item_rdata == 16'd0)
                                                  : (item_rdata == req_q.item);
  assign item_we    = (state_q == S_CLEAR) ||
                      ((state_q == S_SLOT) && cmp_q && slot_hit && (req_q.cmd != CMD_COUNT));
  assign item_waddr = (state_q == S_CLEAR) ? item_raddr : cmp_addr_q;
  assign item_wdata = ((state_q == S_SLOT) && (req_q.cmd == CMD_ADD_ITEM)) ? req_q.item
                                                                            : 16'd0;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (in_i.cmd)
      CMD_ADD_ROW:     bad_req = (in_i.owner == 16'd0) || (in_i.row_key == 16'd0);
      CMD_FIND_OWNER:  bad_req = (in_i.owner == 16'd0);
      CMD_REMOVE_ROW,
      CMD_ADD_ITEM,
      CMD_REMOVE_ITEM,
      CMD_COUNT:       bad_req = (in_i.row_key == 16'd0);
      default:         bad_req = 1'b1;
    endcase
  end

  kst_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(ROW_COUNT)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(ridx),
    .wdata_i(row_wdata),
    .re_i   (row_re),
    .raddr_i(ridx),
    .rdata_o(row_rdata)
  );

  kst_ram #(
    .WIDTH(16),
    .DEPTH(ITEM_DEPTH)
  ) u_item_ram (
    .clk_i  (clk_i),
    .we_i   (item_we),
    .waddr_i(item_waddr),
    .wdata_i(item_wdata),
    .re_i   (item_re),
    .raddr_i(item_raddr),
    .rdata_o(item_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      cmp_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_i;
            res_q <= '{status: bad_req ? STAT_INVALID : STAT_OK, found_key: 16'd0,
                       item_total: 5'd0};
            r_q   <= '0;
            cmp_q <= 1'b0;
            if (bad_req) begin
              state_q <= S_DONE;
            end else if (in_i.cmd == CMD_ADD_ROW) begin
              state_q <= S_FREE;
            end else begin
              state_q <= S_ROW;
            end
          end
        end
        S_FREE: begin
          if (!r_live) begin
            res_q.status <= STAT_FULL;
            state_q      <= S_DONE;
          end else if (!valid_q[ridx]) begin
            valid_q[ridx] <= 1'b1;
            base_q        <= ITEM_AW'(ridx * ITEMS_PER_ROW);
            s_q           <= '0;
            state_q       <= S_CLEAR;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        S_CLEAR: begin
          s_q <= s_q + 1'b1;
          if (s_q == SLOT_CNT_W'(ITEMS_PER_ROW - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_ROW: begin
          cmp_q     <= r_live && !row_hit;
          cmp_row_q <= ridx;
          if (r_live) begin
            r_q <= r_q + 1'b1;
          end
          if (row_hit) begin
            s_q    <= '0;
            cnt_q  <= '0;
            base_q <= ITEM_AW'(cmp_row_q * ITEMS_PER_ROW);
            priority case (1'b1)
              (req_q.cmd == CMD_REMOVE_ROW): begin
                valid_q[cmp_row_q] <= 1'b0;
                state_q            <= S_DONE;
              end
              (req_q.cmd == CMD_FIND_OWNER): begin
                res_q.found_key <= row_rdata.key;
                state_q         <= S_DONE;
              end
              (req_q.cmd != CMD_COUNT && req_q.item == 16'd0): begin
                res_q.status <= STAT_INVALID;
                state_q      <= S_DONE;
              end
              default: begin
                state_q <= S_SLOT;
              end
            endcase
          end else if (!cmp_q && !r_live) begin
            res_q.status <= STAT_NOT_FOUND;
            state_q      <= S_DONE;
          end
        end
        S_SLOT: begin
          cmp_q      <= s_live;
          cmp_addr_q <= item_raddr;
          if (s_live) begin
            s_q <= s_q + 1'b1;
          end
          if (cmp_q && req_q.cmd == CMD_COUNT) begin
            if (item_rdata != 16'd0) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end else if (cmp_q && slot_hit) begin
            state_q <= S_DONE;
          end
          if (!cmp_q && !s_live) begin
            priority case (1'b1)
              (req_q.cmd == CMD_COUNT): begin
                res_q.item_total <= (32'(cnt_q) > 32'd31) ? 5'd31 : 5'(cnt_q);
              end
              (req_q.cmd == CMD_ADD_ITEM): begin
                res_q.status <= STAT_ITEMS_FULL;
              end
              default: begin
                res_q.status <= STAT_NOT_FOUND;
              end
            endcase
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
